[hw/rtl/cossim_pkg.sv]
package cossim_pkg;

    // Vector length at which the running sums reach their clamp
    localparam int unsigned MAX_DIMENSION = 4096;

    localparam int ELEM_W = 16;
    localparam int DOT_W  = 44;
    localparam int NORM_W = 43;
    localparam int PROD_W = 2 * NORM_W;            // norm_a * norm_b, |dot|^2
    localparam int QUO_W  = 34;                    // quotient bits, top one flags overflow
    localparam int REM_W  = PROD_W + 32;           // (|dot| << 16)^2
    localparam int DVS_W  = PROD_W + QUO_W - 1;    // divisor aligned to top quotient bit
    localparam int ROOT_W = 16;
    localparam int ROOT_BIT_W = 4;
    localparam int CNT_W  = 6;

    localparam int MUL_STEPS  = NORM_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_STEPS = ROOT_W;

    // Clamp on every running sum: MAX_DIMENSION full-scale squares, capped by the width
    localparam logic [63:0] DIM_LIMIT = 64'(MAX_DIMENSION) << 30;
    localparam logic [63:0] WIDTH_CAP = (64'd1 << NORM_W) - 64'd1;
    localparam logic [63:0] ACC_LIMIT = (DIM_LIMIT < WIDTH_CAP) ? DIM_LIMIT : WIDTH_CAP;
    localparam logic [NORM_W-1:0] NORM_LIMIT = ACC_LIMIT[NORM_W-1:0];

    localparam logic [ROOT_W-1:0] ROOT_MAX = 16'd32768;
    localparam logic [ROOT_W-1:0] SIM_MAX  = 16'd32767;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
    } acc_t;

    typedef struct packed {
        logic valid;
        acc_t sums;
    } push_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_OUT  = 5'b10000
    } back_state_t;

endpackage

[hw/rtl/cosine_similarity.sv]
// A request with last set passes the product stage and its sums enter the queue; the back end
// then multiplies, divides, takes the root and outputs; a zero magnitude skips to the output.
// Accepts one element pair per cycle unless a last pair waits on a full queue. The back end
// runs 43 shift-add multiply steps, 34 divide steps, 16 root steps, load and output.
// A two-entry queue holds finished sums so the next vector streams in meanwhile.
// Reset (rst_n low, asynchronous): sums, queue and sequencer clear, no result pending.
module cosine_similarity
    import cossim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    input  logic                     elem_valid,
    output logic                     elem_ready,
    output logic signed [ELEM_W-1:0] similarity,
    output logic                     zero_magnitude,
    output logic                     result_valid,
    input  logic                     result_ready
);

    push_t push;
    logic  queue_full;
    logic  head_valid;
    acc_t  head;
    logic  pop;

    cossim_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .last       (last),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .queue_full (queue_full),
        .push       (push)
    );

    cossim_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cossim_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .similarity     (similarity),
        .zero_magnitude (zero_magnitude),
        .result_valid   (result_valid),
        .result_ready   (result_ready)
    );

endmodule

[hw/rtl/cossim_front.sv]
module cossim_front
    import cossim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    input  logic                     elem_valid,
    output logic                     elem_ready,
    input  logic                     queue_full,
    output push_t                    push
);

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [31:0]       pab_reg;
    logic [30:0]              paa_reg;
    logic [30:0]              pbb_reg;

    logic signed [31:0]       prod_ab;
    logic signed [31:0]       prod_aa;
    logic signed [31:0]       prod_bb;

    logic signed [DOT_W-1:0]  dot_reg;
    logic [NORM_W-1:0]        na_reg;
    logic [NORM_W-1:0]        nb_reg;

    logic signed [DOT_W:0]    dot_wide;
    logic signed [DOT_W:0]    dot_lim;
    logic [NORM_W:0]          na_wide;
    logic [NORM_W:0]          nb_wide;
    logic signed [DOT_W-1:0]  dot_next;
    logic [NORM_W-1:0]        na_next;
    logic [NORM_W-1:0]        nb_next;
    logic                     advance;

    // Product stage
    assign prod_ab = elem_a * elem_b;
    assign prod_aa = elem_a * elem_a;
    assign prod_bb = elem_b * elem_b;

    // Stage holds a last request while the queue is full
    assign advance    = s1_valid_reg && !(s1_last_reg && queue_full);
    assign elem_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (elem_ready)
        begin
            s1_valid_reg <= elem_valid;
            s1_last_reg  <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_valid && elem_ready)
        begin
            pab_reg <= prod_ab;
            paa_reg <= prod_aa[30:0];
            pbb_reg <= prod_bb[30:0];
        end
    end

    // Saturating accumulation
    assign dot_lim  = $signed({2'b00, NORM_LIMIT});
    assign dot_wide = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(pab_reg);
    assign na_wide  = {1'b0, na_reg} + (NORM_W+1)'(paa_reg);
    assign nb_wide  = {1'b0, nb_reg} + (NORM_W+1)'(pbb_reg);

    always_comb
    begin
        if (dot_wide > dot_lim)
            dot_next = dot_lim[DOT_W-1:0];
        else if (dot_wide < -dot_lim)
            dot_next = DOT_W'(-dot_lim);
        else
            dot_next = dot_wide[DOT_W-1:0];
        na_next = (na_wide > {1'b0, NORM_LIMIT}) ? NORM_LIMIT : na_wide[NORM_W-1:0];
        nb_next = (nb_wide > {1'b0, NORM_LIMIT}) ? NORM_LIMIT : nb_wide[NORM_W-1:0];
    end

    // Sums clear after the last pair is handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end

    assign push.valid       = advance && s1_last_reg;
    assign push.sums.dot    = dot_next;
    assign push.sums.norm_a = na_next;
    assign push.sums.norm_b = nb_next;

    a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> (dot_reg == '0 && na_reg == '0 && nb_reg == '0))
        else $error("sums not cleared after vector end");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && queue_full) |-> !elem_ready)
        else $error("request taken while last pair is blocked");

    a_norm_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (na_reg <= NORM_LIMIT && nb_reg <= NORM_LIMIT))
        else $error("magnitude sum beyond clamp");

endmodule

[hw/rtl/cossim_queue.sv]
module cossim_queue
    import cossim_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output acc_t  head
);

    acc_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_W'(push.valid) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.sums;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("write into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a write");

endmodule

[hw/rtl/cossim_back.sv]
module cossim_back
    import cossim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  acc_t                     head,
    output logic                     pop,
    output logic signed [ELEM_W-1:0] similarity,
    output logic                     zero_magnitude,
    output logic                     result_valid,
    input  logic                     result_ready
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    logic [NORM_W-1:0]  mcand_reg;
    logic [NORM_W-1:0]  mplier_reg;
    logic [NORM_W-1:0]  dabs_reg;
    logic [NORM_W-1:0]  dscan_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  sq_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [ROOT_W-1:0]  m_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic [ELEM_W-1:0]  similarity_reg;
    logic               zero_magnitude_reg;

    logic [DOT_W-1:0]   dot_mag;
    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  sq_next;
    logic               div_ge;
    logic [QUO_W-2:0]   quo_sat;
    logic [ROOT_W-1:0]  bit_sel;
    logic [ROOT_W-1:0]  cand;
    logic [ROOT_W:0]    odd_k;
    logic [QUO_W-1:0]   odd_sq;
    logic               fit;
    logic [ELEM_W-1:0]  sim_value;
    logic               load_result;

    assign dot_mag = head.dot[DOT_W-1] ? (~head.dot + 1'b1) : head.dot;

    // Shift-add products, one multiplier bit per step
    assign prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                     + (mplier_reg[NORM_W-1] ? PROD_W'(mcand_reg) : '0);
    assign sq_next   = {sq_reg[PROD_W-2:0], 1'b0}
                     + (dscan_reg[NORM_W-1] ? PROD_W'(dabs_reg) : '0);

    // Restoring division step
    assign div_ge  = ({1'b0, rem_reg} >= dvs_reg);
    assign quo_sat = quo_reg[QUO_W-1] ? '1 : quo_reg[QUO_W-2:0];

    // Root search: largest m, at most ROOT_MAX, with (2m-1)^2 not above the saturated quotient
    assign bit_sel = ROOT_W'(1) << cnt_reg[ROOT_BIT_W-1:0];
    assign cand    = m_reg | bit_sel;
    assign odd_k   = {cand, 1'b0} - (ROOT_W+1)'(1);
    assign odd_sq  = QUO_W'(odd_k) * QUO_W'(odd_k);
    assign fit     = (cand <= ROOT_MAX) && (odd_sq <= {1'b0, quo_sat});

    assign sim_value = zero_reg ? '0
                     : neg_reg ? (~m_reg + 1'b1)
                     : ((m_reg > SIM_MAX) ? SIM_MAX : m_reg);

    assign load_result = (state_reg == ST_OUT) && (!result_valid_reg || result_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.norm_a == '0 || head.norm_b == '0)
                        state_next = ST_OUT;
                    else
                    begin
                        state_next = ST_MUL;
                        cnt_next   = CNT_W'(MUL_STEPS - 1);
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_ROOT;
                    cnt_next   = CNT_W'(ROOT_STEPS - 1);
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                    state_next = ST_OUT;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_OUT:
            begin
                if (load_result)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && head_valid)
        begin
            zero_reg   <= (head.norm_a == '0 || head.norm_b == '0);
            neg_reg    <= head.dot[DOT_W-1];
            mcand_reg  <= head.norm_a;
            mplier_reg <= head.norm_b;
            dabs_reg   <= dot_mag[NORM_W-1:0];
            dscan_reg  <= dot_mag[NORM_W-1:0];
            prod_reg   <= '0;
            sq_reg     <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg   <= prod_next;
            sq_reg     <= sq_next;
            mplier_reg <= {mplier_reg[NORM_W-2:0], 1'b0};
            dscan_reg  <= {dscan_reg[NORM_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                rem_reg <= {sq_next, 32'b0};
                dvs_reg <= {prod_next, (QUO_W-1)'(0)};
                quo_reg <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            if (div_ge)
                rem_reg <= rem_reg - dvs_reg[REM_W-1:0];
            dvs_reg <= {1'b0, dvs_reg[DVS_W-1:1]};
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
            if (cnt_reg == '0)
                m_reg <= '0;
        end
        if (state_reg == ST_ROOT && fit)
            m_reg <= cand;
        if (load_result)
        begin
            similarity_reg     <= sim_value;
            zero_magnitude_reg <= zero_reg;
        end
    end

    assign similarity     = $signed(similarity_reg);
    assign zero_magnitude = zero_magnitude_reg;
    assign result_valid   = result_valid_reg;

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && zero_magnitude) |-> similarity == '0)
        else $error("zero-magnitude result carries nonzero similarity");

    a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == '0) |=> state_reg == ST_DIV)
        else $error("multiply phase did not end on count");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && result_valid_reg && !result_ready) |=> state_reg == ST_OUT)
        else $error("result overwritten while waiting");

endmodule
